[src/nas_pkg.sv]
// Shared types, constants and the exp table for the activation block.
package nas_pkg;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 7;   // holds a row length up to 64
  localparam int EXP_W    = 17;  // exp argument and Q16 exp value
  localparam int SUM_W    = 23;  // sum of up to 64 Q16 exp values
  localparam int NUM_W    = 33;  // divider numerator
  localparam int QUOT_W   = 17;  // divider quotient

  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [31:0] LEAK_Q16  = 32'd655;

  // Values of the activation_kind register
  typedef enum logic [2:0] {
    KIND_RELU,
    KIND_SIGMOID,
    KIND_TANH,
    KIND_LEAKY,
    KIND_ROW,
    KIND_RSVD5,
    KIND_RSVD6,
    KIND_RSVD7
  } kind_t;

  // Commands passed from the front to the back
  typedef enum logic [2:0] {
    OP_RELU,
    OP_SIGMOID,
    OP_TANH,
    OP_LRELU,
    OP_PASS,
    OP_ROW
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COUNT_W-1:0]        count;
    logic                      ovf;
  } cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       end_of_row;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       last_of_run;
    logic                       row_overflow;
  } out_item_t;

  // 2^(-i/16) in Q16, i = 0..16
  function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:    v = 17'd65536;
      5'd1:    v = 17'd62757;
      5'd2:    v = 17'd60097;
      5'd3:    v = 17'd57549;
      5'd4:    v = 17'd55109;
      5'd5:    v = 17'd52773;
      5'd6:    v = 17'd50535;
      5'd7:    v = 17'd48393;
      5'd8:    v = 17'd46341;
      5'd9:    v = 17'd44376;
      5'd10:   v = 17'd42495;
      5'd11:   v = 17'd40693;
      5'd12:   v = 17'd38968;
      5'd13:   v = 17'd37316;
      5'd14:   v = 17'd35734;
      5'd15:   v = 17'd34219;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

[src/nas_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module nas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/nas_front.sv]
// Front end: config register, input acceptance, row storage and command queue.
module nas_front #(
  parameter int MAX_COLS = 64,
  parameter int ADDR_W   = $clog2(MAX_COLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  nas_pkg::in_item_t item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_data,
  output logic              cmd_valid,
  output nas_pkg::cmd_t     cmd,
  input  logic              cmd_pop,
  input  logic              row_done,
  output logic              row_busy,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [15:0]       ram_wdata
);
  import nas_pkg::*;

  logic [2:0]         activation_kind;
  logic [COUNT_W-1:0] row_count;
  logic               overflow_seen;
  logic               accept;
  logic               is_row;
  logic               room;
  logic               enq;
  logic               deq;
  logic [COUNT_W-1:0] count_next;
  logic               ovf_next;
  cmd_t               new_cmd;
  cmd_t               q_mem [2];
  logic               wr_ptr;
  logic               rd_ptr;
  logic [1:0]         q_count;

  assign cfg_ready = 1'b1;
  assign full      = (q_count == 2'd2) || row_busy;
  assign accept    = push && !full;
  assign is_row    = (activation_kind == KIND_ROW);
  assign room      = (row_count < COUNT_W'(MAX_COLS));

  // Row storage write
  assign ram_we    = accept && is_row && room;
  assign ram_waddr = row_count[ADDR_W-1:0];
  assign ram_wdata = item.sample_in;

  assign count_next = room ? row_count + 1'b1 : row_count;
  assign ovf_next   = overflow_seen || !room;
  assign enq        = accept && (!is_row || item.end_of_row);
  assign deq        = cmd_pop && cmd_valid;
  assign cmd_valid  = (q_count != 2'd0);
  assign cmd        = q_mem[rd_ptr];

  // Classify the sample into a command
  always_comb begin
    new_cmd.sample = item.sample_in;
    new_cmd.count  = count_next;
    new_cmd.ovf    = ovf_next;
    case (activation_kind)
      KIND_RELU:    new_cmd.op = OP_RELU;
      KIND_SIGMOID: new_cmd.op = OP_SIGMOID;
      KIND_TANH:    new_cmd.op = OP_TANH;
      KIND_LEAKY:   new_cmd.op = OP_LRELU;
      KIND_ROW:     new_cmd.op = OP_ROW;
      default:      new_cmd.op = OP_PASS;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      activation_kind <= KIND_RELU;
      row_count       <= '0;
      overflow_seen   <= 1'b0;
      row_busy        <= 1'b0;
      wr_ptr          <= 1'b0;
      rd_ptr          <= 1'b0;
      q_count         <= 2'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        activation_kind <= cfg_data;
      end
      if (accept && is_row) begin
        if (item.end_of_row) begin
          row_count     <= '0;
          overflow_seen <= 1'b0;
          row_busy      <= 1'b1;
        end else begin
          row_count     <= count_next;
          overflow_seen <= ovf_next;
        end
      end else if (row_done) begin
        row_busy <= 1'b0;
      end
      if (enq) begin
        wr_ptr <= !wr_ptr;
      end
      if (deq) begin
        rd_ptr <= !rd_ptr;
      end
      q_count <= q_count + {1'b0, enq} - {1'b0, deq};
    end
  end

  // Queue payload
  always_ff @(posedge clk) begin
    if (enq) begin
      q_mem[wr_ptr] <= new_cmd;
    end
  end

endmodule

[src/nas_exp.sv]
// Three-stage exp(-n/2048) unit giving a Q16 result.
module nas_exp (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [16:0] arg,
  output logic        done,
  output logic [16:0] value
);
  import nas_pkg::*;

  logic        v1;
  logic        v2;
  logic [33:0] y;
  logic [6:0]  k;
  logic [3:0]  idx;
  logic [11:0] r;
  logic [16:0] a;
  logic [16:0] b;
  logic [11:0] d;
  logic [23:0] prod;
  logic [16:0] frac_v;
  logic [4:0]  k2;
  logic        zero2;
  logic [17:0] rnd;
  logic [17:0] rsum;

  assign k    = y[33:27];
  assign idx  = y[26:23];
  assign r    = y[22:11];
  assign a    = pow2_neg({1'b0, idx});
  assign b    = pow2_neg({1'b0, idx} + 5'd1);
  assign d    = 12'(a - b);
  assign prod = 24'(d) * 24'(r);
  assign rnd  = (k2 == 5'd0) ? 18'd0 : (18'd1 << (k2 - 5'd1));
  assign rsum = {1'b0, frac_v} + rnd;

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start;
      v2   <= v1;
      done <= v2;
    end
  end

  // Data pipeline: scale by log2(e), interpolate, shift by integer part
  always_ff @(posedge clk) begin
    y      <= 34'(arg) * 34'(LOG2E_Q16);
    frac_v <= a - 17'((prod + 24'd2048) >> 12);
    k2     <= k[4:0];
    zero2  <= (k > 7'd16);
    value  <= zero2 ? 17'd0 : 17'(rsum >> k2);
  end

endmodule

[src/nas_div.sv]
// Restoring divider, one quotient bit per cycle, 17-bit quotient.
module nas_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [22:0] den,
  output logic        done,
  output logic [16:0] quot
);

  logic [22:0] rem;
  logic [16:0] low;
  logic [22:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic [23:0] trial;
  logic        ge;

  assign trial = {rem, low[16]};
  assign ge    = (trial >= {1'b0, dvs});

  // Iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd17;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: high bits of the numerator are already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= 23'(num[32:17]);
      low <= num[16:0];
      dvs <= den;
    end else if (busy) begin
      rem  <= ge ? 23'(trial - {1'b0, dvs}) : trial[22:0];
      low  <= {low[15:0], 1'b0};
      quot <= {quot[15:0], ge};
    end
  end

endmodule

[src/nas_back.sv]
// Back end: sequencer that evaluates commands and drives the result register.
module nas_back #(
  parameter int MAX_COLS = 64,
  parameter int ADDR_W   = $clog2(MAX_COLS)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  input  nas_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output logic               row_done,
  output logic [ADDR_W-1:0]  ram_raddr,
  input  logic [15:0]        ram_rdata,
  output logic               empty,
  input  logic               pop,
  output nas_pkg::out_item_t result
);
  import nas_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EW_GO,
    ST_EW_WAIT,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_MAX_RD,
    ST_MAX_CMP,
    ST_SUM_RD,
    ST_SUM_GO,
    ST_SUM_WAIT,
    ST_OUT_RD,
    ST_OUT_GO,
    ST_OUT_WAIT
  } state_t;

  state_t             state;
  op_t                op;
  logic signed [15:0] x;
  logic [COUNT_W-1:0] n;
  logic               ovf;
  logic [COUNT_W-1:0] idx;
  logic signed [15:0] mx;
  logic [SUM_W-1:0]   sum;
  out_item_t          pend;
  logic               out_valid;

  logic               exp_start;
  logic [16:0]        exp_arg;
  logic               exp_done;
  logic [16:0]        exp_val;
  logic               div_start;
  logic [32:0]        div_num;
  logic [22:0]        div_den;
  logic               div_done;
  logic [16:0]        quot;

  logic [16:0]        xe;
  logic [16:0]        ax;
  logic [16:0]        diff;
  logic signed [15:0] ew_val;
  logic signed [31:0] lp;
  logic [17:0]        den_e;
  logic [17:0]        sig_p;
  logic [15:0]        div_val;
  logic               is_last;
  logic               slot_free;
  logic               load_out;

  nas_exp u_exp (
    .clk   (clk),
    .rst   (rst),
    .start (exp_start),
    .arg   (exp_arg),
    .done  (exp_done),
    .value (exp_val)
  );

  nas_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (quot)
  );

  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;
  assign ram_raddr = idx[ADDR_W-1:0];
  assign empty     = !out_valid;
  assign slot_free = !out_valid || pop;
  assign is_last   = (COUNT_W'(idx + 1'b1) == n);
  // Result register takes the pending result this cycle
  assign load_out  = (state == ST_EMIT) && slot_free;

  // Exp argument: |x| or 2|x| for elementwise, max - x over a row
  assign xe   = {x[15], x};
  assign ax   = x[15] ? 17'(-xe) : xe;
  assign diff = {mx[15], mx} - {ram_rdata[15], ram_rdata};

  always_comb begin
    exp_start = 1'b0;
    exp_arg   = diff;
    case (state)
      ST_EW_GO: begin
        exp_start = 1'b1;
        exp_arg   = (op == OP_TANH) ? 17'(ax << 1) : ax;
      end
      ST_SUM_GO, ST_OUT_GO: begin
        exp_start = 1'b1;
      end
      default: ;
    endcase
  end

  // Divider operands, rounded to nearest by adding half the divisor
  assign den_e     = 18'd65536 + 18'(exp_val);
  assign div_start = exp_done && ((state == ST_EW_WAIT) || (state == ST_OUT_WAIT));

  always_comb begin
    if (state == ST_OUT_WAIT) begin
      div_den = sum;
      div_num = (33'(exp_val) << 11) + 33'(sum >> 1);
    end else if (op == OP_TANH) begin
      div_den = 23'(den_e);
      div_num = (33'(17'd65536 - exp_val) << 11) + 33'(den_e >> 1);
    end else begin
      div_den = 23'(den_e);
      div_num = (33'd1 << 32) + 33'(den_e >> 1);
    end
  end

  // Results that need the divider
  assign sig_p = (18'(quot) + 18'd16) >> 5;

  always_comb begin
    case (op)
      OP_SIGMOID: div_val = x[15] ? 16'(18'd2048 - sig_p) : 16'(sig_p);
      OP_TANH:    div_val = x[15] ? 16'(-quot) : 16'(quot);
      default:    div_val = 16'(quot);
    endcase
  end

  // Elementwise results straight from the command
  assign lp = 32'(cmd.sample) * $signed(LEAK_Q16) + 32'sd32768;

  always_comb begin
    case (cmd.op)
      OP_RELU:  ew_val = cmd.sample[15] ? 16'sd0 : cmd.sample;
      OP_LRELU: ew_val = cmd.sample[15] ? lp[31:16] : cmd.sample;
      default:  ew_val = cmd.sample;
    endcase
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
      row_done  <= 1'b0;
    end else begin
      row_done <= load_out && (op == OP_ROW) && is_last;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            op  <= cmd.op;
            x   <= cmd.sample;
            n   <= cmd.count;
            ovf <= cmd.ovf;
            idx <= '0;
            pend.sample_out   <= ew_val;
            pend.last_of_run  <= 1'b1;
            pend.row_overflow <= 1'b0;
            case (cmd.op)
              OP_ROW:               state <= ST_MAX_RD;
              OP_SIGMOID, OP_TANH:  state <= ST_EW_GO;
              default:              state <= ST_EMIT;
            endcase
          end
        end
        ST_EW_GO: state <= ST_EW_WAIT;
        ST_EW_WAIT: begin
          if (exp_done) begin
            state <= ST_DIV_WAIT;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            pend.sample_out   <= div_val;
            pend.last_of_run  <= (op != OP_ROW) || is_last;
            pend.row_overflow <= (op == OP_ROW) && ovf;
            state             <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            result <= pend;
            if (op == OP_ROW && !is_last) begin
              idx   <= idx + 1'b1;
              state <= ST_OUT_RD;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        // Pass 1: row maximum
        ST_MAX_RD: state <= ST_MAX_CMP;
        ST_MAX_CMP: begin
          if (idx == '0 || $signed(ram_rdata) > mx) begin
            mx <= ram_rdata;
          end
          if (is_last) begin
            idx   <= '0;
            sum   <= '0;
            state <= ST_SUM_RD;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_MAX_RD;
          end
        end
        // Pass 2: sum of exp(x - max)
        ST_SUM_RD: state <= ST_SUM_GO;
        ST_SUM_GO: state <= ST_SUM_WAIT;
        ST_SUM_WAIT: begin
          if (exp_done) begin
            sum <= sum + SUM_W'(exp_val);
            if (is_last) begin
              idx   <= '0;
              state <= ST_OUT_RD;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_SUM_RD;
            end
          end
        end
        // Pass 3: normalize each element
        ST_OUT_RD: state <= ST_OUT_GO;
        ST_OUT_GO: state <= ST_OUT_WAIT;
        ST_OUT_WAIT: begin
          if (exp_done) begin
            state <= ST_DIV_WAIT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/neural_activation_softmax_top.sv]
// Top level of the activation block: front end, row RAM and back end.
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | push / full         | item   : sample_in, end_of_row
//  result   | pop / empty         | result : sample_out, last_of_run, row_overflow
//  config   | cfg_valid/cfg_ready | cfg_data : activation_kind
//
// ReLU, leaky ReLU and unused kinds are computed straight from the command;
// sigmoid and tanh go through the 3-stage exp unit and the divider.
// A softmax row is processed after its end mark by a max pass, an exp-sum
// pass, then one exp and one divide per result.
// Reset is synchronous; the row RAM needs no clearing. A two-entry command
// queue lets input transfers continue while a result waits; new input is held
// off while a softmax row is pending, until its last result is loaded.
module neural_activation_softmax_top #(
  parameter int MAX_COLS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  nas_pkg::in_item_t  item,
  output logic               empty,
  input  logic               pop,
  output nas_pkg::out_item_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data
);
  import nas_pkg::*;

  localparam int ADDR_W = $clog2(MAX_COLS);

  logic              cmd_valid;
  cmd_t              cmd;
  logic              cmd_pop;
  logic              row_done;
  logic              row_busy;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  nas_front #(
    .MAX_COLS (MAX_COLS),
    .ADDR_W   (ADDR_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .row_done  (row_done),
    .row_busy  (row_busy),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  nas_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_COLS),
    .AW    (ADDR_W)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nas_back #(
    .MAX_COLS (MAX_COLS),
    .ADDR_W   (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .row_done  (row_done),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // A row finishes only while one is pending
  a_done_when_busy: assert property (@(posedge clk) disable iff (rst)
    row_done |-> row_busy)
    else $error("row done without a pending row");

  // The pending row is released only by the back end
  a_busy_release: assert property (@(posedge clk) disable iff (rst)
    $fell(row_busy) |-> $past(row_done))
    else $error("row busy dropped without row done");

  // No row storage write while the back end reads the row
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    row_busy |-> !ram_we)
    else $error("row RAM written during row processing");

endmodule
